### design/ple_pkg.sv
// Package for the positional list engine: request/result types and codes.
package ple_pkg;

    localparam int unsigned DepthDefault     = 16;
    localparam int unsigned DataWidthDefault = 32;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_READ   = 3'd2;
    localparam logic [2:0] REQ_WRITE  = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_POS = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  position;
        logic [31:0] entry_value;
    } t_req;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [4:0]  list_length;
    } t_rsp;

endpackage

### design/positional_list_engine_unit.sv
// Top level of the positional list engine: request decode, shift sequencer, result register.
// Read, write, clear and rejected requests pass through the decode state S_RD and then S_DONE,
// which registers the result. Insert and remove move one entry at a time through the memory's
// one read and one write port, an S_MRD read and an S_MWR write per entry moved, as the read is registered.
// One request is in flight at a time; the next is accepted the cycle after the result is
// loaded into the output register, and a stalled result holds the sequencer in its last state.
// Synchronous active-low reset clears the length and control state; memory contents
// are undefined until written.
module positional_list_engine_unit #(
    parameter int unsigned DEPTH      = ple_pkg::DepthDefault,
    parameter int unsigned DATA_WIDTH = ple_pkg::DataWidthDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ple_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output ple_pkg::t_rsp o_rsp
);
    import ple_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_MRD   = 3'd2;
    localparam logic [2:0] S_MWR   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    t_req                  r_req;
    logic [CW-1:0]         r_idx, n_idx;
    logic [1:0]            r_status, n_status;
    logic                  r_out_v, n_out_v;
    t_rsp                  r_rsp, n_rsp;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
    logic [DATA_WIDTH-1:0] req_val;
    logic [CW-1:0]         pos_ext;
    logic                  accept;

    ple_store #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign req_val = DATA_WIDTH'(r_req.entry_value);
    assign pos_ext = CW'(r_req.position);

    // Sequencer: check the request, then shift entries one step at a time.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_status  = r_status;
        n_out_v   = r_out_v;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = req_val;
        mem_raddr = r_idx[AW-1:0];
        if (r_out_v && i_ready) begin
            n_out_v = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // Decode and check; reads present the address now.
                n_status = STAT_OK;
                n_state  = S_DONE;
                case (r_req.req_type)
                    REQ_INSERT: begin
                        if ({1'b0, r_req.position} > 6'(r_count)) begin
                            n_status = STAT_BAD_POS;
                        end else if (32'(r_count) >= DEPTH) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_MRD;
                        end
                    end
                    REQ_REMOVE: begin
                        if ({1'b0, r_req.position} >= 6'(r_count)) begin
                            n_status = STAT_BAD_POS;
                        end else begin
                            n_idx   = pos_ext;
                            n_state = S_MRD;
                        end
                    end
                    REQ_READ: begin
                        if ({1'b0, r_req.position} >= 6'(r_count)) begin
                            n_status = STAT_BAD_POS;
                        end else begin
                            mem_raddr = r_req.position[AW-1:0];
                        end
                    end
                    REQ_WRITE: begin
                        if ({1'b0, r_req.position} >= 6'(r_count)) begin
                            n_status = STAT_BAD_POS;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_req.position[AW-1:0];
                        end
                    end
                    REQ_CLEAR: n_count = '0;
                    default: ;
                endcase
            end
            S_MRD: begin
                // Insert: read idx-1 to move back; remove: read idx+1 to move forward.
                if (r_req.req_type == REQ_INSERT) begin
                    if (r_idx == pos_ext) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_idx[AW-1:0];
                        n_count   = r_count + 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        mem_raddr = AW'(r_idx - 1'b1);
                        n_state   = S_MWR;
                    end
                end else begin
                    if (r_idx + 1'b1 >= r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end else begin
                        mem_raddr = AW'(r_idx + 1'b1);
                        n_state   = S_MWR;
                    end
                end
            end
            S_MWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = mem_rdata;
                n_idx     = (r_req.req_type == REQ_INSERT) ? r_idx - 1'b1 : r_idx + 1'b1;
                n_state   = S_MRD;
            end
            S_DONE: begin
                // Keep the read address so a read result survives a wait here.
                mem_raddr = r_req.position[AW-1:0];
                // Result goes out once the output register is free.
                if (!r_out_v) begin
                    n_out_v           = 1'b1;
                    n_rsp.status      = r_status;
                    n_rsp.list_length = 5'(r_count);
                    n_rsp.read_value  = '0;
                    if (r_req.req_type == REQ_READ && r_status == STAT_OK) begin
                        n_rsp.read_value = 32'(mem_rdata);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_out_v <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_rsp    <= n_rsp;
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_rsp;
endmodule

### design/ple_store.sv
// Entry memory of the list with a registered read port.
module ple_store #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32,
    localparam int unsigned AW        = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/ple_checker.sv
// Port-level checker for the positional list engine and its bind.
module ple_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input ple_pkg::t_req i_req,
    input logic          o_valid,
    input logic          i_ready,
    input ple_pkg::t_rsp o_rsp
);
    import ple_pkg::*;

    // A held result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // Status is never the unused code.
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.status != 2'd3)
        else $error("bad status");

    // A failed request carries a zero value.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != STAT_OK |-> o_rsp.read_value == '0)
        else $error("nonzero value on failed request");

    // Full status only with a full-length list.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status == STAT_FULL |-> o_rsp.list_length == 5'(DepthDefault))
        else $error("full reported below capacity");
endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);

### test/tb_positional_list_engine_unit.sv
// Self-checking testbench for the positional list engine: list requests against a local list model.
module tb_positional_list_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ple_pkg::*;

    localparam int Depth = 16;
    localparam int Latency = 3 + 2 * Depth + 8;
    localparam longint CycleLimit = 400000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_req  i_req = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_rsp  o_rsp;

    // Local copy of the list, updated as requests are accepted.
    logic [31:0] list_entries[Depth];
    int          list_len = 0;
    t_rsp        pending_rsps[$];
    int          mismatches = 0;
    int          rsps_seen = 0;
    int          reqs_sent = 0;
    longint      cycle_count = 0;
    bit          rx_idle_allowed = 1'b1;
    bit          tx_idle_allowed = 1'b1;
    int          rx_hold = 0;

    positional_list_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Work out the result of one list request and update the list copy.
    function automatic t_rsp apply_list_request(t_req req);
        t_rsp rsp;
        int   pos;
        rsp = '0;
        pos = req.position;
        case (req.req_type)
            REQ_INSERT: begin
                if (pos > list_len) begin
                    rsp.status = STAT_BAD_POS;
                end else if (list_len >= Depth) begin
                    rsp.status = STAT_FULL;
                end else begin
                    for (int i = list_len; i > pos; i--) list_entries[i] = list_entries[i - 1];
                    list_entries[pos] = req.entry_value;
                    list_len++;
                end
            end
            REQ_REMOVE: begin
                if (pos >= list_len) begin
                    rsp.status = STAT_BAD_POS;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++) list_entries[i] = list_entries[i + 1];
                    list_len--;
                end
            end
            REQ_READ: begin
                if (pos >= list_len) rsp.status = STAT_BAD_POS;
                else rsp.read_value = list_entries[pos];
            end
            REQ_WRITE: begin
                if (pos >= list_len) rsp.status = STAT_BAD_POS;
                else list_entries[pos] = req.entry_value;
            end
            REQ_CLEAR: list_len = 0;
            default: ;
        endcase
        rsp.list_length = list_len[4:0];
        return rsp;
    endfunction

    // Offer one request, with a random idle gap first, and wait for acceptance.
    // Valid stays high after acceptance so that requests can follow back to back.
    task automatic send_request(input logic [2:0] kind, input logic [4:0] pos,
                                input logic [31:0] value);
        while (tx_idle_allowed && $urandom_range(99) < 23) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= '{req_type: kind, position: pos, entry_value: value};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_rsps.push_back(apply_list_request(i_req));
        reqs_sent++;
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(rx_idle_allowed && $urandom_range(99) < 23);
        end
    end

    // Compare each accepted result with the oldest pending one.
    always @(posedge i_clk) begin
        t_rsp want;
        cycle_count++;
        if (i_rst_n && o_valid && i_ready) begin
            rsps_seen++;
            if (pending_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", o_rsp);
            end else begin
                want = pending_rsps.pop_front();
                if (want.read_value !== o_rsp.read_value || want.status !== o_rsp.status
                        || want.list_length !== o_rsp.list_length) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, o_rsp);
                end
            end
        end
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Field extremes, every request kind and each corner on an empty and a short list.
    task automatic test_directed();
        send_request(REQ_READ, 5'd0, 32'h0);
        send_request(REQ_REMOVE, 5'd0, 32'h0);
        send_request(REQ_WRITE, 5'd31, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 5'd1, 32'h1234_5678);
        send_request(REQ_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 5'd0, 32'h0000_0000);
        send_request(REQ_INSERT, 5'd2, 32'hA5A5_5A5A);
        send_request(REQ_READ, 5'd1, 32'h0);
        send_request(REQ_WRITE, 5'd1, 32'h5A5A_A5A5);
        send_request(REQ_READ, 5'd1, 32'h0);
        send_request(REQ_REMOVE, 5'd0, 32'h0);
        send_request(REQ_READ, 5'd3, 32'h0);
        send_request(3'd5, 5'd0, 32'h0);
        send_request(3'd6, 5'd17, 32'h1);
        send_request(3'd7, 5'd31, 32'hFFFF_FFFF);
        send_request(REQ_CLEAR, 5'd31, 32'hFFFF_FFFF);
        send_request(REQ_READ, 5'd0, 32'h0);
    endtask

    // Fill to capacity, try inserting into a full list, then drain.
    task automatic test_full_list();
        for (int i = 0; i < Depth; i++) send_request(REQ_INSERT, 5'(i), $urandom);
        send_request(REQ_INSERT, 5'd16, 32'hDEAD_BEEF);
        send_request(REQ_INSERT, 5'd0, 32'hDEAD_BEEF);
        send_request(REQ_INSERT, 5'd17, 32'hDEAD_BEEF);
        send_request(REQ_READ, 5'd15, 32'h0);
        send_request(REQ_REMOVE, 5'd15, 32'h0);
        while (list_len > 0) send_request(REQ_REMOVE, 5'($urandom_range(list_len - 1)), 32'h0);
    endtask

    // Receiver holds off for a long stretch so the engine backs up its input.
    task automatic test_backpressure();
        rx_hold = 300;
        for (int i = 0; i < 10; i++) send_request(REQ_INSERT, 5'd0, $urandom);
        send_request(REQ_CLEAR, 5'd0, 32'h0);
    endtask

    // Random requests, mostly in range; with no_idle set, neither side idles.
    task automatic test_random(input int count, input bit no_idle);
        logic [2:0] kind;
        logic [4:0] pos;
        rx_idle_allowed = !no_idle;
        tx_idle_allowed = !no_idle;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: kind = REQ_INSERT;
                6, 7, 8:          kind = REQ_REMOVE;
                9, 10, 11, 12:    kind = REQ_READ;
                13, 14, 15:       kind = REQ_WRITE;
                16:               kind = REQ_CLEAR;
                default:          kind = 3'($urandom_range(7));
            endcase
            if ($urandom_range(9) == 0) pos = 5'($urandom);
            else pos = 5'($urandom_range(list_len));
            send_request(kind, pos, $urandom);
        end
        rx_idle_allowed = 1'b1;
        tx_idle_allowed = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_list();
        test_backpressure();
        test_random(300, 1'b0);
        test_random(60, 1'b1);
        i_valid <= 1'b0;
        while (pending_rsps.size() > 0) @(posedge i_clk);
        repeat (Latency) @(posedge i_clk);
        $display("Sent %0d list requests and checked %0d results, covering empty, full,",
                 reqs_sent, rsps_seen);
        $display("out-of-range, unused-code and back-pressure cases.");
        if (mismatches == 0 && pending_rsps.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
design/ple_pkg.sv
design/ple_store.sv
design/positional_list_engine_unit.sv
design/ple_checker.sv
test/tb_positional_list_engine_unit.sv
